[rtl/mlbq_pkg.sv]
// ----------------------------------------------------------------------------
// mlbq_pkg
// Shared constants, codes and the command type of the multi-level byte queue.
// ----------------------------------------------------------------------------
package mlbq_pkg;

    localparam int NUM_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 256;    // power of two: pointers wrap by masking
    localparam int MAX_BURST   = 16;

    localparam int QCOUNT    = NUM_LEVELS - 1;
    localparam int Q_W       = (QCOUNT > 1) ? $clog2(QCOUNT) : 1;
    localparam int PTR_W     = $clog2(LEVEL_DEPTH);
    localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
    localparam int MEM_DEPTH = QCOUNT * LEVEL_DEPTH;
    localparam int ADDR_W    = Q_W + PTR_W;
    localparam int TOT_W     = $clog2(MEM_DEPTH + 1);
    localparam int BURST_W   = $clog2(MAX_BURST + 1);
    localparam int CQ_DEPTH  = 2;
    localparam int CQ_PTR_W  = 1;
    localparam int CQ_CNT_W  = 2;

    // Fixed field widths
    localparam int REQ_W   = 2;
    localparam int LVL_W   = 3;
    localparam int DATA_W  = 8;
    localparam int RCNT_W  = 5;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 11;

    // Request types
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Result status
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_LEVEL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SHORT     = 2'd3;

    // Classified command kinds
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BAD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BAD_READ  = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   kind;
        logic               all_levels;
        logic [Q_W-1:0]     q;
        logic [DATA_W-1:0]  data;
        logic [BURST_W-1:0] count;
    } cmd_t;

endpackage

[rtl/mlbq_decode.sv]
// ----------------------------------------------------------------------------
// mlbq_decode
// Classifies an incoming request into a command for the execution side.
// ----------------------------------------------------------------------------
module mlbq_decode
(
    input  logic [mlbq_pkg::REQ_W-1:0]  req_type,
    input  logic [mlbq_pkg::LVL_W-1:0]  level,
    input  logic [mlbq_pkg::DATA_W-1:0] data_byte,
    input  logic [mlbq_pkg::RCNT_W-1:0] read_count,
    output mlbq_pkg::cmd_t              cmd,
    output logic                        keep
);
    import mlbq_pkg::*;

    logic lvl_zero;
    logic lvl_ok;

    always_comb
    begin
        lvl_zero = (level == '0);
        lvl_ok   = !lvl_zero && (32'(level) < NUM_LEVELS);

        cmd.all_levels = lvl_zero;
        cmd.q          = Q_W'(level - LVL_W'(1));
        cmd.data       = data_byte;
        cmd.count      = (32'(read_count) > MAX_BURST) ? BURST_W'(MAX_BURST)
                                                        : BURST_W'(read_count);
        keep     = 1'b1;
        cmd.kind = CMD_CLEAR;
        case (req_type)
            REQ_WRITE: cmd.kind = lvl_ok ? CMD_WRITE : CMD_BAD_WRITE;
            REQ_READ:  cmd.kind = (lvl_ok || lvl_zero) ? CMD_READ : CMD_BAD_READ;
            REQ_CLEAR: cmd.kind = CMD_CLEAR;
            default:   keep = 1'b0;     // unused request type: swallowed
        endcase
    end

endmodule

[rtl/mlbq_cmd_queue.sv]
// ----------------------------------------------------------------------------
// mlbq_cmd_queue
// Short command queue decoupling request intake from execution.
// ----------------------------------------------------------------------------
module mlbq_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  mlbq_pkg::cmd_t wr_cmd,
    output logic           full,
    output logic           rd_valid,
    output mlbq_pkg::cmd_t rd_cmd,
    input  logic           rd_pop
);
    import mlbq_pkg::*;

    cmd_t                entry_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] fill_reg, fill_next;
    logic                push, pop;

    assign full     = (fill_reg == CQ_CNT_W'(CQ_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign push     = wr_en && !full;
    assign pop      = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[rtl/mlbq_exec.sv]
// ----------------------------------------------------------------------------
// mlbq_exec
// Executes commands: level counts, byte store, burst sequencer, result register.
// ----------------------------------------------------------------------------
module mlbq_exec
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  mlbq_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mlbq_pkg::DATA_W-1:0] out_byte,
    output logic [mlbq_pkg::LVL_W-1:0]  source_level,
    output logic                        has_data,
    output logic [mlbq_pkg::STAT_W-1:0] status,
    output logic [mlbq_pkg::FILL_W-1:0] level_fill,
    output logic                        last
);
    import mlbq_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RD_ADDR = 2'd1;
    localparam logic [1:0] ST_RD_DATA = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [PTR_W-1:0]   head_reg [QCOUNT];
    logic [PTR_W-1:0]   head_next [QCOUNT];
    logic [CNT_W-1:0]   cnt_reg [QCOUNT];
    logic [CNT_W-1:0]   cnt_next [QCOUNT];
    logic [TOT_W-1:0]   total_reg, total_next;

    logic               rd_all_reg, rd_all_next;
    logic [Q_W-1:0]     rd_q_reg, rd_q_next;
    logic [BURST_W-1:0] rd_left_reg, rd_left_next;
    logic [FILL_W-1:0]  rd_fill_reg, rd_fill_next;
    logic [LVL_W-1:0]   rd_src_reg, rd_src_next;

    logic [DATA_W-1:0]  mem [MEM_DEPTH];
    logic [DATA_W-1:0]  mem_q_reg;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;

    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_byte_reg;
    logic [LVL_W-1:0]   src_reg;
    logic               has_data_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               last_reg;

    logic               load;
    logic [DATA_W-1:0]  res_byte;
    logic [LVL_W-1:0]   res_src;
    logic               res_has;
    logic [STAT_W-1:0]  res_status;
    logic [FILL_W-1:0]  res_fill;
    logic               res_last;

    logic               out_free;
    logic [Q_W-1:0]     first_q;
    logic [Q_W-1:0]     sel_q;
    logic [TOT_W-1:0]   avail;
    logic [CNT_W-1:0]   cur_cnt;
    logic [PTR_W-1:0]   cur_head;

    assign out_free = !out_valid_reg || !out_stall;

    // lowest non-empty level for a drain over all levels
    always_comb
    begin
        first_q = '0;
        for (int i = QCOUNT - 1; i >= 0; i--)
        begin
            if (cnt_reg[i] != '0)
            begin
                first_q = Q_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        rd_all_next  = rd_all_reg;
        rd_q_next    = rd_q_reg;
        rd_left_next = rd_left_reg;
        rd_fill_next = rd_fill_reg;
        rd_src_next  = rd_src_reg;

        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = {cmd.q, head_reg[cmd.q] + cnt_reg[cmd.q][PTR_W-1:0]};
        sel_q      = rd_all_reg ? first_q : rd_q_reg;
        mem_raddr  = {sel_q, head_reg[sel_q]};
        cur_cnt    = cnt_reg[cmd.q];
        cur_head   = head_reg[sel_q];
        avail      = cmd.all_levels ? total_reg : TOT_W'(cur_cnt);

        load       = 1'b0;
        res_byte   = '0;
        res_src    = '0;
        res_has    = 1'b0;
        res_status = STAT_OK;
        res_fill   = '0;
        res_last   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_WRITE:
                        begin
                            load = 1'b1;
                            if (cur_cnt == CNT_W'(LEVEL_DEPTH))
                            begin
                                res_status = STAT_FULL;
                                res_fill   = FILL_W'(cur_cnt);
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                cnt_next[cmd.q] = cur_cnt + 1'b1;
                                total_next      = total_reg + 1'b1;
                                res_fill        = FILL_W'(cur_cnt + 1'b1);
                            end
                        end
                        CMD_READ:
                        begin
                            if (cmd.count == '0)
                            begin
                                load     = 1'b1;
                                res_fill = FILL_W'(avail);
                            end
                            else if (avail < TOT_W'(cmd.count))
                            begin
                                load       = 1'b1;
                                res_status = STAT_SHORT;
                                res_fill   = FILL_W'(avail);
                            end
                            else
                            begin
                                // fill after the whole burst is known up front
                                rd_all_next  = cmd.all_levels;
                                rd_q_next    = cmd.q;
                                rd_left_next = cmd.count;
                                rd_fill_next = FILL_W'(avail - TOT_W'(cmd.count));
                                state_next   = ST_RD_ADDR;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            load       = 1'b1;
                            total_next = '0;
                            for (int i = 0; i < QCOUNT; i++)
                            begin
                                head_next[i] = '0;
                                cnt_next[i]  = '0;
                            end
                        end
                        CMD_BAD_WRITE:
                        begin
                            load       = 1'b1;
                            res_status = STAT_BAD_LEVEL;
                            res_fill   = cmd.all_levels ? FILL_W'(total_reg) : '0;
                        end
                        CMD_BAD_READ:
                        begin
                            load       = 1'b1;
                            res_status = STAT_SHORT;
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            ST_RD_ADDR:
            begin
                mem_re           = 1'b1;
                head_next[sel_q] = cur_head + 1'b1;
                cnt_next[sel_q]  = cnt_reg[sel_q] - 1'b1;
                total_next       = total_reg - 1'b1;
                rd_src_next      = LVL_W'(sel_q) + LVL_W'(1);
                rd_left_next     = rd_left_reg - 1'b1;
                state_next       = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    res_byte   = mem_q_reg;
                    res_src    = rd_src_reg;
                    res_has    = 1'b1;
                    res_fill   = rd_fill_reg;
                    res_last   = (rd_left_reg == '0);
                    state_next = (rd_left_reg == '0) ? ST_IDLE : ST_RD_ADDR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_all_reg    <= 1'b0;
            rd_q_reg      <= '0;
            rd_left_reg   <= '0;
            for (int i = 0; i < QCOUNT; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            rd_all_reg    <= rd_all_next;
            rd_q_reg      <= rd_q_next;
            rd_left_reg   <= rd_left_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_fill_reg <= rd_fill_next;
        rd_src_reg  <= rd_src_next;
        if (load)
        begin
            out_byte_reg <= res_byte;
            src_reg      <= res_src;
            has_data_reg <= res_has;
            status_reg   <= res_status;
            fill_reg     <= res_fill;
            last_reg     <= res_last;
        end
    end

    // byte store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.data;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign source_level = src_reg;
    assign has_data     = has_data_reg;
    assign status       = status_reg;
    assign level_fill   = fill_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD_ADDR |-> cnt_reg[sel_q] != '0)
        else $error("burst pops an empty level");

    a_data_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD_DATA |->
            $past(state_reg) == ST_RD_ADDR || $past(state_reg) == ST_RD_DATA)
        else $error("read data state entered without a store read");

    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD_DATA && out_free && rd_left_reg == '0 |=>
            state_reg == ST_IDLE && out_valid_reg && last_reg && has_data_reg)
        else $error("final burst byte not marked last");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= MEM_DEPTH)
        else $error("total count out of range");
`endif

endmodule

[rtl/multi_level_byte_queue.sv]
// ----------------------------------------------------------------------------
// multi_level_byte_queue
// Byte FIFO per priority level with burst reads that can drain all levels.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): req_type, level, data_byte, read_count.
//   Requests are classified and placed in a two-entry command queue; in_stall
//   rises only when that queue is full. Unused request types are taken and
//   dropped with no result.
// Output channel (out_valid / out_stall): one result per write, clear, refused
//   read or zero-count read; any other read gives read_count results (clamped
//   to the burst limit), last set on the final one. level_fill on every result
//   of a request is the fill after the whole request.
// Flow: with the executor idle, a taken request goes through the command queue
//   and its result is then loaded into the result register. Each burst byte
//   takes a store read, then a result load, and the bytes of a burst alternate
//   between these two states. Writes, clears and status replies sustain one
//   item per cycle while the output is not stalled.
// A stalled output holds the result register and pauses the executor; the
//   command queue keeps taking items until it fills.
// Reset clears all counts, pointers and the command queue; the byte store
//   itself needs no initialisation.
// ----------------------------------------------------------------------------
module multi_level_byte_queue
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mlbq_pkg::REQ_W-1:0]  req_type,
    input  logic [mlbq_pkg::LVL_W-1:0]  level,
    input  logic [mlbq_pkg::DATA_W-1:0] data_byte,
    input  logic [mlbq_pkg::RCNT_W-1:0] read_count,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mlbq_pkg::DATA_W-1:0] out_byte,
    output logic [mlbq_pkg::LVL_W-1:0]  source_level,
    output logic                        has_data,
    output logic [mlbq_pkg::STAT_W-1:0] status,
    output logic [mlbq_pkg::FILL_W-1:0] level_fill,
    output logic                        last
);
    import mlbq_pkg::*;

    cmd_t dec_cmd;
    cmd_t q_cmd;
    logic dec_keep;
    logic q_full;
    logic q_valid;
    logic q_pop;

    mlbq_decode u_decode
    (
        .req_type   (req_type),
        .level      (level),
        .data_byte  (data_byte),
        .read_count (read_count),
        .cmd        (dec_cmd),
        .keep       (dec_keep)
    );

    mlbq_cmd_queue u_cmd_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_valid && dec_keep),
        .wr_cmd   (dec_cmd),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd),
        .rd_pop   (q_pop)
    );

    assign in_stall = q_full;

    mlbq_exec u_exec
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd          (q_cmd),
        .cmd_pop      (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .source_level (source_level),
        .has_data     (has_data),
        .status       (status),
        .level_fill   (level_fill),
        .last         (last)
    );

endmodule
